// ===== rtl/core/bsa_pkg.sv =====
package bsa_pkg;

  // Pool geometry: the free map is kept as words of one bit per slot.
  localparam int unsigned Slots   = 1024;
  localparam int unsigned WordW   = 32;
  localparam int unsigned Words   = Slots / WordW;
  localparam int unsigned AddrW   = $clog2(Words);
  localparam int unsigned BitW    = $clog2(WordW);
  localparam int unsigned SlotW   = 10;
  localparam int unsigned IdxW    = 11;
  localparam int unsigned CountW  = 11;

  typedef logic [WordW-1:0] word_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [BitW-1:0]  bitpos_t;

  // Requested operation.
  typedef enum logic [0:0] {
    FN_ALLOC = 1'b0,
    FN_FREE  = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    func_e           func;
    logic [IdxW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SlotW-1:0]  given_slot;
    status_e           status;
    logic [CountW-1:0] free_slots;
  } rsp_t;

  // Access to the word store for one cycle.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
  } store_req_t;

  // Position of the lowest set bit; zero when no bit is set.
  function automatic bitpos_t first_one(input word_t w);
    bitpos_t pos;
    pos = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = bitpos_t'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bsa_word_store.sv =====
// Free map storage: one word of free bits per entry, with a registered read
// port. Entries never written since reset read as all free.
module bsa_word_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsa_pkg::store_req_t  req_i,
  output bsa_pkg::word_t       rd_data_o
);

  bsa_pkg::word_t              mem [bsa_pkg::Words];
  logic [bsa_pkg::Words-1:0]   written_q;
  bsa_pkg::word_t              rdata_q;
  logic                        rd_written_q;

  // Memory array: write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q      <= mem[req_i.rd_addr];
      rd_written_q <= written_q[req_i.rd_addr];
    end
  end

  // Per-entry written flags, cleared at once by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (req_i.wr_en) begin
      written_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_written_q ? rdata_q : '1;

endmodule

// ===== rtl/core/bitmap_slot_allocator.sv =====
// Channel  | Ports                    | Transfer
// ---------+--------------------------+--------------------------------------
// request  | start, busy, req_i       | at the edge where start=1, busy=0
// result   | done_o, rsp_o            | at the edge ending the done_o cycle
//
// For each request the map word is read from the word store at the accepting
// edge, then modified and written back in the following cycle. The result is
// registered and appears in the cycle after that, when busy is already low, so
// a new request may be accepted while the previous result is shown. Reset
// marks every slot free at once. The receiver cannot stall the result.
module bitmap_slot_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bsa_pkg::req_t req_i,
  output logic          done_o,
  output bsa_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_MODIFY = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [bsa_pkg::Words-1:0]     summary_q, summary_d;
  logic [bsa_pkg::CountW-1:0]    count_q, count_d;
  bsa_pkg::func_e                func_q;
  logic [bsa_pkg::IdxW-1:0]      idx_q;
  bsa_pkg::addr_t                addr_q, addr_d;
  logic                          empty_q;
  logic                          done_q, done_d;
  bsa_pkg::rsp_t                 rsp_q, rsp_d;
  bsa_pkg::store_req_t           store_req;
  bsa_pkg::word_t                word;
  bsa_pkg::word_t                new_word;
  bsa_pkg::bitpos_t              alloc_bit;
  bsa_pkg::bitpos_t              free_bit;
  logic                          accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q == S_MODIFY);

  // Word address: first word with a free slot, or the word holding the slot.
  always_comb begin
    if (req_i.func == bsa_pkg::FN_ALLOC) begin
      addr_d = bsa_pkg::addr_t'(bsa_pkg::first_one(summary_q));
    end else begin
      addr_d = req_i.slot_index[bsa_pkg::AddrW+bsa_pkg::BitW-1:bsa_pkg::BitW];
    end
  end

  assign alloc_bit = bsa_pkg::first_one(word);
  assign free_bit  = idx_q[bsa_pkg::BitW-1:0];

  // Read, modify and write back the map word; form the result.
  always_comb begin
    state_d             = state_q;
    summary_d           = summary_q;
    count_d             = count_q;
    done_d              = 1'b0;
    rsp_d               = rsp_q;
    new_word            = word;
    store_req.rd_en     = accept;
    store_req.rd_addr   = addr_d;
    store_req.wr_en     = 1'b0;
    store_req.wr_addr   = addr_q;
    store_req.wr_data   = new_word;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MODIFY;
        end
      end
      S_MODIFY: begin
        state_d          = S_IDLE;
        done_d           = 1'b1;
        rsp_d.granted    = 1'b0;
        rsp_d.given_slot = '0;
        rsp_d.status     = bsa_pkg::ST_OK;
        if (func_q == bsa_pkg::FN_ALLOC) begin
          if (empty_q) begin
            rsp_d.status = bsa_pkg::ST_EMPTY;
          end else begin
            new_word[alloc_bit] = 1'b0;
            store_req.wr_en     = 1'b1;
            summary_d[addr_q]   = |new_word;
            count_d             = count_q - bsa_pkg::CountW'(1);
            rsp_d.granted       = 1'b1;
            rsp_d.given_slot    = {addr_q, alloc_bit};
          end
        end else if (idx_q >= bsa_pkg::IdxW'(bsa_pkg::Slots)) begin
          rsp_d.status = bsa_pkg::ST_RANGE;
        end else if (!word[free_bit]) begin
          new_word[free_bit] = 1'b1;
          store_req.wr_en    = 1'b1;
          summary_d[addr_q]  = 1'b1;
          count_d            = count_q + bsa_pkg::CountW'(1);
        end
        store_req.wr_data = new_word;
        rsp_d.free_slots  = count_d;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  bsa_word_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (word)
  );

  // Control state, free count and the summary of words with free slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      summary_q <= '1;
      count_q   <= bsa_pkg::CountW'(bsa_pkg::Slots);
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      summary_q <= summary_d;
      count_q   <= count_d;
      done_q    <= done_d;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      idx_q   <= req_i.slot_index;
      addr_q  <= addr_d;
      empty_q <= ~|summary_q;
    end
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
